// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge outside reset
`define CSV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check on every rising edge, reset included
`define CSV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/csv_tok_pkg.sv =====
package csv_tok_pkg;

    // payload widths
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 8;
    localparam int LEN_OUT_W = 16;
    localparam int CFG_IDX_W = 3;

    // parameter defaults
    localparam int MAX_FIELDS_DEF  = 255;
    localparam int LENGTH_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR = 3'd3;

    // configuration reset values
    localparam logic [BYTE_W-1:0] DELIMITER_RST  = 8'd44;  // comma
    localparam logic [BYTE_W-1:0] QUOTE_RST      = 8'd34;  // double quote
    localparam logic [BYTE_W-1:0] ESCAPE_RST     = 8'd92;  // backslash
    localparam logic [BYTE_W-1:0] TERMINATOR_RST = 8'd10;  // newline

    // parser mode
    typedef enum logic [1:0] {
        MODE_START,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_SKIP
    } mode_t;

endpackage

// ===== hw/rtl/csv_field_tokenizer_core.sv =====
// channel   | direction | ports                                  | handshake
// ----------+-----------+----------------------------------------+--------------------
// input     | in        | s_in_byte                              | s_valid / s_ready
// result    | out       | m_out_byte, m_is_content, m_field_done,| m_valid / m_ready
//           |           | m_record_end, m_field_number,          |
//           |           | m_field_length, m_column_count,        |
//           |           | m_bad_quote                            |
// config    | in        | cfg_index, cfg_data                    | cfg_wr_en
//
// one byte per cycle sustained while m_ready is high; a byte passes the input register
// then the result register; the rate is set by the update loop of the mode and the counters
// an input register and a result register each hold one item; stalls on m_ready
// back up through both to s_ready in the same cycle
// aresetn is synchronous, active low; it restores the default characters and clears state
`include "assert_macros.svh"

module csv_field_tokenizer_core #(
    parameter int MAX_FIELDS  = csv_tok_pkg::MAX_FIELDS_DEF,
    parameter int LENGTH_BITS = csv_tok_pkg::LENGTH_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [csv_tok_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csv_tok_pkg::BYTE_W-1:0]      cfg_data,
    // input bytes
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [csv_tok_pkg::BYTE_W-1:0]      s_in_byte,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [csv_tok_pkg::BYTE_W-1:0]      m_out_byte,
    output logic                                m_is_content,
    output logic                                m_field_done,
    output logic                                m_record_end,
    output logic [csv_tok_pkg::COUNT_W-1:0]     m_field_number,
    output logic [csv_tok_pkg::LEN_OUT_W-1:0]   m_field_length,
    output logic [csv_tok_pkg::COUNT_W-1:0]     m_column_count,
    output logic                                m_bad_quote
);

    localparam int LEN_W = (LENGTH_BITS < csv_tok_pkg::LEN_OUT_W) ?
                           LENGTH_BITS : csv_tok_pkg::LEN_OUT_W;
    localparam int FIELD_CAP_INT = (MAX_FIELDS < 255) ? MAX_FIELDS : 255;
    localparam logic [csv_tok_pkg::COUNT_W-1:0] FIELD_CAP =
        csv_tok_pkg::COUNT_W'(FIELD_CAP_INT);
    localparam logic [LEN_W-1:0] LEN_CAP = '1;

    // configuration registers
    logic [csv_tok_pkg::BYTE_W-1:0] delim_reg;
    logic [csv_tok_pkg::BYTE_W-1:0] quote_reg;
    logic [csv_tok_pkg::BYTE_W-1:0] escape_reg;
    logic [csv_tok_pkg::BYTE_W-1:0] term_reg;

    // input stage
    logic                           in_valid_reg, in_valid_next;
    logic [csv_tok_pkg::BYTE_W-1:0] in_byte_reg;

    // parser state
    csv_tok_pkg::mode_t              mode_reg, mode_next;
    logic                            last_esc_reg, last_esc_next;
    logic [csv_tok_pkg::COUNT_W-1:0] field_idx_reg, field_idx_next;
    logic [LEN_W-1:0]                content_len_reg, content_len_next;

    // result stage
    logic                            out_valid_reg, out_valid_next;
    logic [csv_tok_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                            out_content_reg;
    logic                            out_fend_reg;
    logic                            out_rend_reg;
    logic [csv_tok_pkg::COUNT_W-1:0] out_fnum_reg;
    logic [LEN_W-1:0]                out_flen_reg;
    logic [csv_tok_pkg::COUNT_W-1:0] out_cols_reg;
    logic                            out_bad_reg;

    // combinational results
    logic                            res_content;
    logic                            res_fend;
    logic                            res_rend;
    logic [LEN_W-1:0]                res_flen;
    logic [csv_tok_pkg::COUNT_W-1:0] res_cols;
    logic                            res_bad;
    logic [csv_tok_pkg::COUNT_W-1:0] field_inc;
    logic [LEN_W-1:0]                len_inc;

    logic out_load;
    logic stage_xfer;
    logic s_accept;

    // handshake
    assign out_load   = !out_valid_reg || m_ready;
    assign stage_xfer = in_valid_reg && out_load;
    assign s_ready    = !in_valid_reg || out_load;
    assign s_accept   = s_valid && s_ready;

    // configuration writes, indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg  <= csv_tok_pkg::DELIMITER_RST;
            quote_reg  <= csv_tok_pkg::QUOTE_RST;
            escape_reg <= csv_tok_pkg::ESCAPE_RST;
            term_reg   <= csv_tok_pkg::TERMINATOR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                csv_tok_pkg::CFG_DELIMITER:  delim_reg  <= cfg_data;
                csv_tok_pkg::CFG_QUOTE:      quote_reg  <= cfg_data;
                csv_tok_pkg::CFG_ESCAPE:     escape_reg <= cfg_data;
                csv_tok_pkg::CFG_TERMINATOR: term_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (stage_xfer) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_in_byte;
        end
    end

    // saturating increments
    assign field_inc = (field_idx_reg < FIELD_CAP) ? field_idx_reg + 1'b1 : FIELD_CAP;
    assign len_inc   = (content_len_reg == LEN_CAP) ? LEN_CAP : content_len_reg + 1'b1;

    // parser: terminator wins in every mode, then per-mode handling
    always_comb begin
        mode_next        = mode_reg;
        field_idx_next   = field_idx_reg;
        content_len_next = content_len_reg;
        last_esc_next    = (in_byte_reg == escape_reg);
        res_content      = 1'b0;
        res_fend         = 1'b0;
        res_rend         = 1'b0;
        res_flen         = '0;
        res_cols         = '0;
        res_bad          = 1'b0;

        if (in_byte_reg == term_reg) begin
            res_rend = 1'b1;
            if (mode_reg == csv_tok_pkg::MODE_PLAIN || mode_reg == csv_tok_pkg::MODE_QUOTED) begin
                res_fend = 1'b1;
                res_flen = content_len_reg;
                res_cols = field_inc;
                res_bad  = (mode_reg == csv_tok_pkg::MODE_QUOTED);
            end else begin
                // trailing delimiter, empty line or closed quoted field: no extra column
                res_cols = field_idx_reg;
            end
            mode_next        = csv_tok_pkg::MODE_START;
            field_idx_next   = '0;
            content_len_next = '0;
        end else begin
            unique case (mode_reg)
                csv_tok_pkg::MODE_START: begin
                    content_len_next = '0;
                    if (in_byte_reg == quote_reg) begin
                        mode_next = csv_tok_pkg::MODE_QUOTED;
                    end else if (in_byte_reg == delim_reg) begin
                        res_fend       = 1'b1;
                        field_idx_next = field_inc;
                    end else begin
                        res_content      = 1'b1;
                        content_len_next = LEN_W'(1);
                        res_flen         = LEN_W'(1);
                        mode_next        = csv_tok_pkg::MODE_PLAIN;
                    end
                end
                csv_tok_pkg::MODE_PLAIN: begin
                    if (in_byte_reg == delim_reg) begin
                        res_fend         = 1'b1;
                        res_flen         = content_len_reg;
                        field_idx_next   = field_inc;
                        content_len_next = '0;
                        mode_next        = csv_tok_pkg::MODE_START;
                    end else begin
                        res_content      = 1'b1;
                        content_len_next = len_inc;
                        res_flen         = len_inc;
                    end
                end
                csv_tok_pkg::MODE_QUOTED: begin
                    // closing quote only when the raw previous byte was not the escape
                    if (in_byte_reg == quote_reg && !last_esc_reg) begin
                        res_fend         = 1'b1;
                        res_flen         = content_len_reg;
                        field_idx_next   = field_inc;
                        content_len_next = '0;
                        mode_next        = csv_tok_pkg::MODE_SKIP;
                    end else begin
                        res_content      = 1'b1;
                        content_len_next = len_inc;
                        res_flen         = len_inc;
                    end
                end
                default: begin
                    // byte after a closing quote is dropped
                    mode_next        = csv_tok_pkg::MODE_START;
                    content_len_next = '0;
                end
            endcase
        end
    end

    // parser state advances as an item moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= csv_tok_pkg::MODE_START;
            last_esc_reg    <= 1'b0;
            field_idx_reg   <= '0;
            content_len_reg <= '0;
        end else if (stage_xfer) begin
            mode_reg        <= mode_next;
            last_esc_reg    <= last_esc_next;
            field_idx_reg   <= field_idx_next;
            content_len_reg <= content_len_next;
        end
    end

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (stage_xfer) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_xfer) begin
            out_byte_reg    <= in_byte_reg;
            out_content_reg <= res_content;
            out_fend_reg    <= res_fend;
            out_rend_reg    <= res_rend;
            out_fnum_reg    <= field_idx_reg;
            out_flen_reg    <= res_flen;
            out_cols_reg    <= res_cols;
            out_bad_reg     <= res_bad;
        end
    end

    // outputs
    assign m_valid        = out_valid_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_is_content   = out_content_reg;
    assign m_field_done   = out_fend_reg;
    assign m_record_end   = out_rend_reg;
    assign m_field_number = out_fnum_reg;
    assign m_field_length = csv_tok_pkg::LEN_OUT_W'(out_flen_reg);
    assign m_column_count = out_cols_reg;
    assign m_bad_quote    = out_bad_reg;

    // checks
    `CSV_ASSERT(a_bad_quote_ends, out_valid_reg && out_bad_reg |-> out_rend_reg && out_fend_reg, "bad quote without field and record end")
    `CSV_ASSERT(a_content_not_end, out_valid_reg && out_content_reg |-> !out_fend_reg && !out_rend_reg, "content byte also marked as an end")
    `CSV_ASSERT(a_record_restart, stage_xfer && res_rend |=> mode_reg == csv_tok_pkg::MODE_START && field_idx_reg == '0 && content_len_reg == '0, "parser not restarted after record end")
    `CSV_ASSERT(a_cols_only_at_end, out_valid_reg && !out_rend_reg |-> out_cols_reg == '0, "column count outside record end")

endmodule
